[rtl/bhwdm_pkg.sv]
// ============================================================================
// bhwdm_pkg
// Shared types and constants for the byte/half/word data memory: command
// and status codes, memory geometry and the request and result records.
// ============================================================================
`default_nettype none

package bhwdm_pkg;

    // Memory geometry: byte count is a power of two, split over four byte banks
    localparam int MEM_BYTES = 8192;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int BANKS     = 4;
    localparam int ROWS      = MEM_BYTES / BANKS;
    localparam int ROW_AW    = MEM_AW - 2;
    localparam int PTR_W     = MEM_AW + 1;

    localparam logic [31:0] BASE_RESET = 32'h1001_0000;
    localparam logic [7:0]  BYTE_MASK  = 8'hff;

    // Command codes
    localparam logic [3:0] CMD_LB  = 4'd0;
    localparam logic [3:0] CMD_LH  = 4'd1;
    localparam logic [3:0] CMD_LW  = 4'd2;
    localparam logic [3:0] CMD_SB  = 4'd3;
    localparam logic [3:0] CMD_SH  = 4'd4;
    localparam logic [3:0] CMD_SW  = 4'd5;
    localparam logic [3:0] CMD_APB = 4'd6;
    localparam logic [3:0] CMD_APH = 4'd7;
    localparam logic [3:0] CMD_APW = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_MISALIGNED = 2'd1;
    localparam logic [1:0] ST_RANGE      = 2'd2;

    // Access size as log2 of the byte count
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] address;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
    } rsp_t;

endpackage

`default_nettype wire

[rtl/bhwdm_bank.sv]
// ============================================================================
// bhwdm_bank
// One byte-wide bank of the data memory: single port, synchronous write,
// registered read data from the addressed row.
// ============================================================================
`default_nettype none

module bhwdm_bank (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [bhwdm_pkg::ROW_AW-1:0] addr,
    input  wire logic [7:0]                   wdata,
    output logic      [7:0]                   rdata
);
    import bhwdm_pkg::*;

    logic [7:0] mem [ROWS];

    // Write and read the addressed row
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[rtl/byte_half_word_data_memory.sv]
// ============================================================================
// byte_half_word_data_memory
// Little-endian byte-addressed data memory with byte, half and word loads
// (sign-extended, unaligned allowed), aligned stores and pointer appends.
// ============================================================================
//
//  channel   signals                      direction  transfer
//  --------  ---------------------------  ---------  -------------------------
//  command   start, busy, request         in         start && !busy
//  result    done, result                 out        done, one cycle, no stall
//  config    cfg_valid, cfg_ready, cfg_data in       cfg_valid && cfg_ready
//
//  One command per cycle while busy is low: four byte banks let any byte, half
//  or word (aligned or not) touch each bank once, so the result appears in the
//  cycle after acceptance, together with the registered bank read data.
//  After reset the banks are zeroed one row per cycle over all ROWS = 2048
//  rows, with busy high; configuration writes are taken throughout.
//  The receiver cannot stall: done is a one-cycle strobe.
// ============================================================================
`default_nettype none

module byte_half_word_data_memory (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire bhwdm_pkg::req_t request,
    output logic                 done,
    output bhwdm_pkg::rsp_t      result,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [31:0]     cfg_data
);
    import bhwdm_pkg::*;

    localparam logic [1:0] K_NONE   = 2'd0;
    localparam logic [1:0] K_LOAD   = 2'd1;
    localparam logic [1:0] K_STORE  = 2'd2;
    localparam logic [1:0] K_APPEND = 2'd3;

    logic [31:0]       base_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic              clearing_reg;
    logic [ROW_AW-1:0] clr_reg;

    logic              done_reg;
    logic [1:0]        status_reg;
    logic              load_ok_reg;
    logic [1:0]        lg_reg;
    logic [1:0]        rot_reg;

    logic              accept;
    logic [1:0]        kind;
    logic [1:0]        lg;
    logic [2:0]        size;
    logic [31:0]       off;
    logic [32:0]       end_ls;
    logic              fits_ls;
    logic [PTR_W-1:0]  p_sum;
    logic [PTR_W-1:0]  p_aligned;
    logic [PTR_W:0]    end_ap;
    logic              fits_ap;
    logic              aligned;
    logic [MEM_AW-1:0] eff;
    logic              do_write;
    logic [1:0]        status_next;

    logic              bank_we    [BANKS];
    logic [ROW_AW-1:0] bank_addr  [BANKS];
    logic [7:0]        bank_wdata [BANKS];
    logic [7:0]        bank_rdata [BANKS];

    logic [31:0]       word;
    logic [31:0]       load_value;

    assign accept    = start && !busy;
    assign busy      = clearing_reg;
    assign cfg_ready = 1'b1;

    // Decode the command into access kind and size
    always_comb
    begin
        kind = K_NONE;
        lg   = SZ_BYTE;
        case (request.command)
            CMD_LB:  begin kind = K_LOAD;   lg = SZ_BYTE; end
            CMD_LH:  begin kind = K_LOAD;   lg = SZ_HALF; end
            CMD_LW:  begin kind = K_LOAD;   lg = SZ_WORD; end
            CMD_SB:  begin kind = K_STORE;  lg = SZ_BYTE; end
            CMD_SH:  begin kind = K_STORE;  lg = SZ_HALF; end
            CMD_SW:  begin kind = K_STORE;  lg = SZ_WORD; end
            CMD_APB: begin kind = K_APPEND; lg = SZ_BYTE; end
            CMD_APH: begin kind = K_APPEND; lg = SZ_HALF; end
            CMD_APW: begin kind = K_APPEND; lg = SZ_WORD; end
            default: begin kind = K_NONE;   lg = SZ_BYTE; end
        endcase
    end

    // Range, alignment and append pointer rounding
    always_comb
    begin
        size      = 3'd1 << lg;
        off       = request.address - base_reg;
        end_ls    = {1'b0, off} + 33'(size);
        fits_ls   = end_ls <= 33'(MEM_BYTES);
        aligned   = (request.address[2:0] & (size - 3'd1)) == 3'd0;
        p_sum     = ptr_reg + PTR_W'(size - 3'd1);
        p_aligned = p_sum & ~PTR_W'(size - 3'd1);
        end_ap    = {1'b0, p_aligned} + (PTR_W + 1)'(size);
        fits_ap   = end_ap <= (PTR_W + 1)'(MEM_BYTES);
        eff       = (kind == K_APPEND) ? p_aligned[MEM_AW-1:0] : off[MEM_AW-1:0];

        do_write    = 1'b0;
        status_next = ST_OK;
        ptr_next    = ptr_reg;
        case (kind)
            K_LOAD:
            begin
                if (!fits_ls)
                begin
                    status_next = ST_RANGE;
                end
            end
            K_STORE:
            begin
                if (!aligned)
                begin
                    status_next = ST_MISALIGNED;
                end
                else if (!fits_ls)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    do_write = accept;
                end
            end
            K_APPEND:
            begin
                if (!fits_ap)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    do_write = accept;
                    ptr_next = p_aligned + PTR_W'(size);
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Steer each byte of the access to its bank; the clear pass overrides
    always_comb
    begin
        logic [1:0] k;
        for (int b = 0; b < BANKS; b++)
        begin
            k = 2'(b) - eff[1:0];
            if (clearing_reg)
            begin
                bank_we[b]    = 1'b1;
                bank_addr[b]  = clr_reg;
                bank_wdata[b] = 8'h00;
            end
            else
            begin
                bank_we[b]    = do_write && ({1'b0, k} < size);
                bank_addr[b]  = eff[MEM_AW-1:2] + ROW_AW'(2'(b) < eff[1:0]);
                bank_wdata[b] = request.write_data[{k, 3'b000} +: 8] & BYTE_MASK;
            end
        end
    end

    for (genvar g = 0; g < BANKS; g++)
    begin : g_bank
        bhwdm_bank u_bank (
            .clk   (clk),
            .we    (bank_we[g]),
            .addr  (bank_addr[g]),
            .wdata (bank_wdata[g]),
            .rdata (bank_rdata[g])
        );
    end

    // Hold control state: base, pointer, clear pass and result tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= BASE_RESET;
            ptr_reg      <= '0;
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
            if (clearing_reg)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == ROW_AW'(ROWS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                ptr_reg <= ptr_next;
            end
            done_reg <= accept;
        end
    end

    // Capture the transaction details for the result cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            load_ok_reg <= (kind == K_LOAD) && fits_ls;
            lg_reg      <= lg;
            rot_reg     <= eff[1:0];
        end
    end

    // Rotate bank bytes into order and sign-extend
    always_comb
    begin
        for (int k = 0; k < BANKS; k++)
        begin
            word[8*k +: 8] = bank_rdata[2'(k) + rot_reg];
        end
        case (lg_reg)
            SZ_BYTE: load_value = {{24{word[7]}}, word[7:0]};
            SZ_HALF: load_value = {{16{word[15]}}, word[15:0]};
            default: load_value = word;
        endcase
    end

    assign done             = done_reg;
    assign result.read_data = load_ok_reg ? load_value : 32'd0;
    assign result.status    = status_reg;

endmodule

`default_nettype wire
